@@ rtl/core/erm_pkg.sv @@
package erm_pkg;

  localparam int TrigIterations = 16;
  localparam int TableLen       = 24;
  localparam int IterCount      = (TrigIterations > TableLen) ? TableLen : TrigIterations;
  localparam int FractionBits   = 14;
  localparam int OutFrac        = 14;

  // CORDIC datapath widths
  localparam int TrigW = FractionBits + 3;
  localparam int AngW  = 32;
  localparam int ProdW = 2 * TrigW;

  localparam int FullTurn    = 23040;
  localparam int HalfTurn    = 11520;
  localparam int QuarterTurn = 5760;

  localparam longint GainQ30 = 64'd652032854;
  // gain rounded to FractionBits, ties up
  localparam longint GainFix = (GainQ30 + (64'd1 << (30 - FractionBits - 1)))
                               >>> (30 - FractionBits);

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } erm_out_t;

  // atan(2^-i) in degrees * 2^22
  function automatic logic signed [AngW-1:0] atan_lut(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0: v = 32'sd188743680;  1: v = 32'sd111421900;  2: v = 32'sd58872272;
      3: v = 32'sd29884485;   4: v = 32'sd15000234;   5: v = 32'sd7507429;
      6: v = 32'sd3754631;    7: v = 32'sd1877430;    8: v = 32'sd938729;
      9: v = 32'sd469366;     10: v = 32'sd234683;    11: v = 32'sd117342;
      12: v = 32'sd58671;     13: v = 32'sd29335;     14: v = 32'sd14668;
      15: v = 32'sd7334;      16: v = 32'sd3667;      17: v = 32'sd1833;
      18: v = 32'sd917;       19: v = 32'sd458;       20: v = 32'sd229;
      21: v = 32'sd115;       22: v = 32'sd57;        23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // product rounded back to FractionBits, ties up
  function automatic logic signed [TrigW-1:0] fmul(input logic signed [TrigW-1:0] a,
                                                   input logic signed [TrigW-1:0] b);
    logic signed [ProdW-1:0] p;
    p = ProdW'(a) * ProdW'(b);
    p = p + (ProdW'(1) <<< (FractionBits - 1));
    return TrigW'(p >>> FractionBits);
  endfunction

  // convert to Q1.14 and saturate at +-1.0
  function automatic logic signed [15:0] to_out(input logic signed [TrigW+1:0] v);
    logic signed [TrigW+OutFrac+1:0] r;
    if (FractionBits >= OutFrac) begin
      r = (TrigW+OutFrac+2)'(v);
      if (FractionBits > OutFrac)
        r = (r + ((TrigW+OutFrac+2)'(1) <<< ((FractionBits > OutFrac) ?
             (FractionBits - OutFrac - 1) : 0))) >>> (FractionBits - OutFrac);
    end else begin
      r = (TrigW+OutFrac+2)'(v) <<< (OutFrac - FractionBits);
    end
    if (r > 16384) r = (TrigW+OutFrac+2)'(16384);
    if (r < -16384) r = (TrigW+OutFrac+2)'(-16384);
    return 16'(r);
  endfunction

endpackage

@@ rtl/core/euler_rotation_matrix.sv @@
// Registers in order: stage 0, CORDIC stages, quadrant fix, products, output.
// Throughput: one request per cycle; busy is never raised. The CORDIC runs one
// micro-rotation per stage for all three angles, products take two stages.
// Reset (rst_n low, synchronous) clears every valid bit; no result is lost or
// repeated since the receiver cannot stall.
module euler_rotation_matrix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  erm_pkg::erm_in_t in_data,
  output logic             out_valid,
  output erm_pkg::erm_out_t out_data
);

  localparam int N  = erm_pkg::IterCount;
  localparam int TW = erm_pkg::TrigW;
  localparam int AW = erm_pkg::AngW;

  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [AW-1:0] ang_t;

  assign busy = 1'b0;

  // stage 0: angle reduction (mod by constant, narrow values)
  ang_t  z0_nxt [3];
  logic  flip0_nxt [3];

  always_comb begin
    logic signed [17:0] a;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: a = 18'(in_data.angle_x);
        1: a = 18'(in_data.angle_y);
        default: a = 18'(in_data.angle_z);
      endcase
      // |a| < 32768 so at most two turns are added or one turn is removed
      if (a < 0) a = a + 18'(erm_pkg::FullTurn);
      if (a < 0) a = a + 18'(erm_pkg::FullTurn);
      if (a >= 18'(erm_pkg::FullTurn)) a = a - 18'(erm_pkg::FullTurn);
      if (a > 18'(erm_pkg::HalfTurn)) a = a - 18'(erm_pkg::FullTurn);
      flip0_nxt[k] = 1'b0;
      if (a > 18'(erm_pkg::QuarterTurn)) begin
        a = a - 18'(erm_pkg::HalfTurn);
        flip0_nxt[k] = 1'b1;
      end else if (a < -18'(erm_pkg::QuarterTurn)) begin
        a = a + 18'(erm_pkg::HalfTurn);
        flip0_nxt[k] = 1'b1;
      end
      z0_nxt[k] = AW'(a) <<< 16;
    end
  end

  // stage 0 registers and CORDIC stages, one micro-rotation each
  trig_t cx_r [N+1][3];
  trig_t cy_r [N+1][3];
  ang_t  cz_r [N+1][3];
  logic  cf_r [N+1][3];
  logic  [N:0] cv_r;
  trig_t x_nxt [N][3];
  trig_t y_nxt [N][3];
  ang_t  z_nxt [N][3];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (!cz_r[i][k][AW-1]) begin
          x_nxt[i][k] = cx_r[i][k] - (cy_r[i][k] >>> i);
          y_nxt[i][k] = cy_r[i][k] + (cx_r[i][k] >>> i);
          z_nxt[i][k] = cz_r[i][k] - erm_pkg::atan_lut(i);
        end else begin
          x_nxt[i][k] = cx_r[i][k] + (cy_r[i][k] >>> i);
          y_nxt[i][k] = cy_r[i][k] - (cx_r[i][k] >>> i);
          z_nxt[i][k] = cz_r[i][k] + erm_pkg::atan_lut(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= '0;
    else cv_r <= {cv_r[N-1:0], start};
    for (int k = 0; k < 3; k++) begin
      cx_r[0][k] <= trig_t'(erm_pkg::GainFix);
      cy_r[0][k] <= '0;
      cz_r[0][k] <= z0_nxt[k];
      cf_r[0][k] <= flip0_nxt[k];
    end
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < 3; k++) begin
        cx_r[i+1][k] <= x_nxt[i][k];
        cy_r[i+1][k] <= y_nxt[i][k];
        cz_r[i+1][k] <= z_nxt[i][k];
        cf_r[i+1][k] <= cf_r[i][k];
      end
    end
  end

  // quadrant fix: sine and cosine per axis
  trig_t s_r [3];
  trig_t c_r [3];
  logic  vs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else vs_r <= cv_r[N];
    for (int k = 0; k < 3; k++) begin
      s_r[k] <= cf_r[N][k] ? -cy_r[N][k] : cy_r[N][k];
      c_r[k] <= cf_r[N][k] ? -cx_r[N][k] : cx_r[N][k];
    end
  end

  // first products
  trig_t czsy_r, szsy_r, czcy_r, szcy_r, cysx_r, cycx_r, szcx_r, czcx_r, szsx_r, czsx_r;
  trig_t p_sx_r, p_cx_r, p_sy_r;
  logic  vp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else vp_r <= vs_r;
    czsy_r <= erm_pkg::fmul(c_r[2], s_r[1]);
    szsy_r <= erm_pkg::fmul(s_r[2], s_r[1]);
    czcy_r <= erm_pkg::fmul(c_r[2], c_r[1]);
    szcy_r <= erm_pkg::fmul(s_r[2], c_r[1]);
    cysx_r <= erm_pkg::fmul(c_r[1], s_r[0]);
    cycx_r <= erm_pkg::fmul(c_r[1], c_r[0]);
    szcx_r <= erm_pkg::fmul(s_r[2], c_r[0]);
    czcx_r <= erm_pkg::fmul(c_r[2], c_r[0]);
    szsx_r <= erm_pkg::fmul(s_r[2], s_r[0]);
    czsx_r <= erm_pkg::fmul(c_r[2], s_r[0]);
    p_sx_r <= s_r[0];
    p_cx_r <= c_r[0];
    p_sy_r <= s_r[1];
  end

  // triple products, sums and output conversion
  erm_pkg::erm_out_t out_nxt;
  always_comb begin
    logic signed [TW+1:0] e3, e4, e6, e7;
    e3 = (TW+2)'(erm_pkg::fmul(czsy_r, p_sx_r)) - (TW+2)'(szcx_r);
    e4 = (TW+2)'(erm_pkg::fmul(szsy_r, p_sx_r)) + (TW+2)'(czcx_r);
    e6 = (TW+2)'(erm_pkg::fmul(czsy_r, p_cx_r)) + (TW+2)'(szsx_r);
    e7 = (TW+2)'(erm_pkg::fmul(szsy_r, p_cx_r)) - (TW+2)'(czsx_r);
    out_nxt.m00 = erm_pkg::to_out((TW+2)'(czcy_r));
    out_nxt.m01 = erm_pkg::to_out((TW+2)'(szcy_r));
    out_nxt.m02 = erm_pkg::to_out(-(TW+2)'(p_sy_r));
    out_nxt.m10 = erm_pkg::to_out(e3);
    out_nxt.m11 = erm_pkg::to_out(e4);
    out_nxt.m12 = erm_pkg::to_out((TW+2)'(cysx_r));
    out_nxt.m20 = erm_pkg::to_out(e6);
    out_nxt.m21 = erm_pkg::to_out(e7);
    out_nxt.m22 = erm_pkg::to_out((TW+2)'(cycx_r));
  end

  logic out_valid_r;
  erm_pkg::erm_out_t out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vp_r;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r |=> vp_r) else $error("product stage lost a request");
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !vp_r |=> !out_valid) else $error("result without request");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.m00 <= 16384 && out_data.m00 >= -16384
                   && out_data.m22 <= 16384 && out_data.m22 >= -16384))
    else $error("entry out of range");
`endif

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

  localparam int Latency = erm_pkg::IterCount + 3;
  localparam int NumRandom = 1100;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  erm_pkg::erm_in_t in_data;
  logic out_valid;
  erm_pkg::erm_out_t out_data;

  euler_rotation_matrix i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data)
  );

  // atan(2^-i) in degrees * 2^22
  localparam longint AtanDeg[24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  // floor division by 2^s
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // round to nearest, ties up
  function automatic longint round_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shr(a * b, erm_pkg::FractionBits);
  endfunction

  // CORDIC sine and cosine of an angle in 1/64 degree
  task automatic cordic_sincos(input logic signed [15:0] raw, output longint s,
                               output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    int n;
    a = raw;
    flip = 0;
    a = a % erm_pkg::FullTurn;
    if (a < 0) a += erm_pkg::FullTurn;
    if (a > erm_pkg::HalfTurn) a -= erm_pkg::FullTurn;
    if (a > erm_pkg::QuarterTurn) begin
      a -= erm_pkg::HalfTurn;
      flip = 1;
    end else if (a < -erm_pkg::QuarterTurn) begin
      a += erm_pkg::HalfTurn;
      flip = 1;
    end
    n = (erm_pkg::TrigIterations > 24) ? 24 : erm_pkg::TrigIterations;
    x = round_shr(erm_pkg::GainQ30, 30 - erm_pkg::FractionBits);
    y = 0;
    z = a * 65536;
    for (int i = 0; i < n; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= AtanDeg[i];
      end else begin
        x += dx;
        y -= dy;
        z += AtanDeg[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    if (erm_pkg::FractionBits >= erm_pkg::OutFrac)
      r = round_shr(v, erm_pkg::FractionBits - erm_pkg::OutFrac);
    else r = v * (64'sd1 <<< (erm_pkg::OutFrac - erm_pkg::FractionBits));
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  // expected rotation matrix for one set of angles
  task automatic rotation_matrix(input erm_pkg::erm_in_t a, output erm_pkg::erm_out_t m);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    cordic_sincos(a.angle_x, sx, cx);
    cordic_sincos(a.angle_y, sy, cy);
    cordic_sincos(a.angle_z, sz, cz);
    czsy = qmul(cz, sy);
    szsy = qmul(sz, sy);
    m.m00 = to_q14(qmul(cz, cy));
    m.m01 = to_q14(qmul(sz, cy));
    m.m02 = to_q14(-sy);
    m.m10 = to_q14(qmul(czsy, sx) - qmul(sz, cx));
    m.m11 = to_q14(qmul(szsy, sx) + qmul(cz, cx));
    m.m12 = to_q14(qmul(cy, sx));
    m.m20 = to_q14(qmul(czsy, cx) + qmul(sz, sx));
    m.m21 = to_q14(qmul(szsy, cx) - qmul(cz, sx));
    m.m22 = to_q14(qmul(cy, cx));
  endtask

  class matrix_scoreboard;
    erm_pkg::erm_out_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task note_request(erm_pkg::erm_in_t a);
      erm_pkg::erm_out_t m;
      rotation_matrix(a, m);
      pending.push_back(m);
    endtask

    function void check_field(string name, logic signed [15:0] e, logic signed [15:0] g);
      if (e !== g) begin
        $error("%s: expected %0d, got %0d", name, e, g);
        errors++;
      end
    endfunction

    function void check_matrix(erm_pkg::erm_out_t g);
      erm_pkg::erm_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected matrix out");
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("m00", e.m00, g.m00);
      check_field("m01", e.m01, g.m01);
      check_field("m02", e.m02, g.m02);
      check_field("m10", e.m10, g.m10);
      check_field("m11", e.m11, g.m11);
      check_field("m12", e.m12, g.m12);
      check_field("m20", e.m20, g.m20);
      check_field("m21", e.m21, g.m21);
      check_field("m22", e.m22, g.m22);
    endfunction
  endclass

  matrix_scoreboard sb = new();
  int gap_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // request accept and matrix check at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_data);
      if (out_valid) sb.check_matrix(out_data);
    end
  end

  // hold one request until accepted
  task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
    erm_pkg::erm_in_t a;
    a.angle_x = ax;
    a.angle_y = ay;
    a.angle_z = az;
    in_data <= a;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // angle mix: full 16 bit range, legal range, multiples of 90 degrees and values near them
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(erm_pkg::QuarterTurn * $signed($urandom_range(0, 16))
                    - 4 * erm_pkg::QuarterTurn);
      2: return 16'(erm_pkg::QuarterTurn * $signed($urandom_range(0, 16))
                    - 4 * erm_pkg::QuarterTurn + $signed($urandom_range(0, 4)) - 2);
      default: return 16'($signed($urandom_range(0, 2 * erm_pkg::FullTurn))
                          - erm_pkg::FullTurn);
    endcase
  endfunction

  task automatic idle_gap();
    start <= 1'b0;
    in_data <= '0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  initial begin
    logic signed [15:0] corner[12];
    int waited;
    corner = '{16'sh0, 16'sd1, -16'sd1, 16'sd5760, -16'sd5760, 16'sd11520,
               -16'sd11520, 16'sd23040, -16'sd23040, 16'sh7fff, 16'sh8000, 16'sd2880};
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, quadrant edges, wrap beyond a full turn
    for (int i = 0; i < 12; i++) send_angles(corner[i], corner[(i + 4) % 12],
                                             corner[(i + 8) % 12]);
    send_angles(16'sd5759, 16'sd5761, -16'sd5761);
    send_angles(16'sd23041, -16'sd23041, 16'sd11519);
    send_angles(16'sh5555, 16'shaaaa, 16'sh7fff);
    idle_gap();

    // random bursts with random gaps
    gap_left = NumRandom;
    while (gap_left > 0) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && gap_left > 0; i++) begin
        send_angles(rand_angle(), rand_angle(), rand_angle());
        gap_left--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 10 * Latency + 100) begin
      @(negedge clk);
      waited++;
    end
    repeat (Latency + 5) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
